@@ src/rhsv_pkg.sv @@
package rhsv_pkg;

  localparam int PIX_W = 8;
  localparam int HN_W  = 11;
  localparam int NUM_W = 17;
  localparam int DEN_W = 9;
  localparam int Q_W   = 8;

  localparam logic [6:0] HUE_MUL = 7'd85;
  localparam logic [8:0] SAT_MUL = 9'd510;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic [Q_W-1:0]   quot_t;

endpackage

@@ src/rhsv_div.sv @@
module rhsv_div (
  input  logic          clk,
  input  rhsv_pkg::num_t  num,
  input  rhsv_pkg::den_t  den,
  output rhsv_pkg::quot_t quot
);

  localparam int NUM_W = rhsv_pkg::NUM_W;
  localparam int DEN_W = rhsv_pkg::DEN_W;
  localparam int Q_W   = rhsv_pkg::Q_W;
  localparam int SUB_W = NUM_W + 1;

  logic [NUM_W-1:0] rem_in [0:Q_W-1];
  logic [DEN_W-1:0] den_in [0:Q_W-1];
  logic [Q_W-1:0]   q_in   [0:Q_W-1];

  logic [NUM_W-1:0] rem_r  [1:Q_W-1];
  logic [DEN_W-1:0] den_r  [1:Q_W-1];
  logic [Q_W-1:0]   q_r    [1:Q_W];

  genvar k;
  generate
    for (k = 0; k < Q_W; k++) begin : g_stage
      logic [SUB_W-1:0] sub_ext;
      logic [SUB_W-1:0] diff;
      logic             ge;

      if (k == 0) begin : g_first
        assign rem_in[k] = num;
        assign den_in[k] = den;
        assign q_in[k]   = '0;
      end else begin : g_next
        assign rem_in[k] = rem_r[k];
        assign den_in[k] = den_r[k];
        assign q_in[k]   = q_r[k];
      end

      // one quotient bit per stage, msb first
      assign sub_ext = SUB_W'(den_in[k]) << (Q_W - 1 - k);
      assign diff    = {1'b0, rem_in[k]} - sub_ext;
      assign ge      = ~diff[SUB_W-1];

      always_ff @(posedge clk) begin
        q_r[k+1] <= {q_in[k][Q_W-2:0], ge};
      end

      if (k < Q_W - 1) begin : g_carry
        always_ff @(posedge clk) begin
          rem_r[k+1] <= ge ? diff[NUM_W-1:0] : rem_in[k];
          den_r[k+1] <= den_in[k];
        end
      end
    end
  endgenerate

  assign quot = q_r[Q_W];

endmodule

@@ src/rgb_to_hsv_full_byte.sv @@
// rgb to hsv converter, one pixel per beat, full-byte hue circle
//
// input: drive in_red, in_green, in_blue with start high; the pixel is
// taken at the clock edge where start is high and busy is low. busy is
// held low, so a new pixel can be taken on every clock.
//
// output: out_valid is high for exactly one cycle per pixel with
// out_hue, out_saturation and out_brightness. the receiver cannot stall;
// the beat is taken at the edge that ends that cycle.
//
// pipeline: three front stages (max/min, hue numerator, scaling) and
// eight stages of a restoring divider, one quotient bit each, two
// dividers side by side for hue and saturation. throughput is one pixel
// per cycle.
//
// reset: synchronous active-low rst_n clears all valid bits; pixels in
// flight are dropped and no result comes out until new pixels are taken.
module rgb_to_hsv_full_byte (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rhsv_pkg::pix_t    in_red,
  input  rhsv_pkg::pix_t    in_green,
  input  rhsv_pkg::pix_t    in_blue,
  output logic              out_valid,
  output rhsv_pkg::quot_t   out_hue,
  output rhsv_pkg::quot_t   out_saturation,
  output rhsv_pkg::pix_t    out_brightness
);

  localparam int PIX_W = rhsv_pkg::PIX_W;
  localparam int HN_W  = rhsv_pkg::HN_W;
  localparam int SN_W  = HN_W + 1;
  localparam int NUM_W = rhsv_pkg::NUM_W;
  localparam int DEN_W = rhsv_pkg::DEN_W;
  localparam int Q_W   = rhsv_pkg::Q_W;
  localparam int LAT   = 3 + Q_W;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  logic             accept;
  logic [LAT-1:0]   valid_r;
  logic [LAT-1:0]   valid_nxt;

  // stage 1
  rhsv_pkg::pix_t   s1_red_r, s1_green_r, s1_blue_r;
  rhsv_pkg::pix_t   s1_max_r, s1_min_r;
  logic [1:0]       s1_sel_r;
  rhsv_pkg::pix_t   s1_max_nxt, s1_min_nxt;
  logic [1:0]       s1_sel_nxt;

  // stage 2
  rhsv_pkg::pix_t   s2_d_r, s2_max_r;
  logic [HN_W-1:0]  s2_n_r;
  rhsv_pkg::pix_t   s2_d_nxt;
  logic [HN_W-1:0]  s2_n_nxt;
  logic signed [SN_W-1:0] r_s, g_s, b_s, d_s, d6_s, n_raw, n_wrap;

  // stage 3
  rhsv_pkg::num_t   s3_hnum_r, s3_snum_r;
  rhsv_pkg::den_t   s3_hden_r, s3_sden_r;
  rhsv_pkg::pix_t   s3_max_r;

  rhsv_pkg::pix_t   br_r [0:Q_W-1];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign valid_nxt = {valid_r[LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r[LAT-1];

  // max channel with ties to red, then green
  always_comb begin
    if (in_red >= in_green && in_red >= in_blue) begin
      s1_sel_nxt = SEL_RED;
      s1_max_nxt = in_red;
    end else if (in_green >= in_blue) begin
      s1_sel_nxt = SEL_GREEN;
      s1_max_nxt = in_green;
    end else begin
      s1_sel_nxt = SEL_BLUE;
      s1_max_nxt = in_blue;
    end
    s1_min_nxt = in_red;
    if (in_green < s1_min_nxt) s1_min_nxt = in_green;
    if (in_blue < s1_min_nxt) s1_min_nxt = in_blue;
  end

  always_ff @(posedge clk) begin
    s1_red_r   <= in_red;
    s1_green_r <= in_green;
    s1_blue_r  <= in_blue;
    s1_max_r   <= s1_max_nxt;
    s1_min_r   <= s1_min_nxt;
    s1_sel_r   <= s1_sel_nxt;
  end

  // hue numerator over 6*delta, wrapped into one turn
  assign s2_d_nxt = s1_max_r - s1_min_r;
  assign r_s  = signed'({{(SN_W-PIX_W){1'b0}}, s1_red_r});
  assign g_s  = signed'({{(SN_W-PIX_W){1'b0}}, s1_green_r});
  assign b_s  = signed'({{(SN_W-PIX_W){1'b0}}, s1_blue_r});
  assign d_s  = signed'({{(SN_W-PIX_W){1'b0}}, s2_d_nxt});
  assign d6_s = (d_s <<< 2) + (d_s <<< 1);

  always_comb begin
    unique case (s1_sel_r)
      SEL_RED:   n_raw = g_s - b_s;
      SEL_GREEN: n_raw = (d_s <<< 1) + b_s - r_s;
      SEL_BLUE:  n_raw = (d_s <<< 2) + r_s - g_s;
      default:   n_raw = '0;
    endcase
    if (n_raw < 0) begin
      n_wrap = n_raw + d6_s;
    end else if (n_raw >= d6_s) begin
      n_wrap = n_raw - d6_s;
    end else begin
      n_wrap = n_raw;
    end
  end

  assign s2_n_nxt = n_wrap[HN_W-1:0];

  always_ff @(posedge clk) begin
    s2_d_r   <= s2_d_nxt;
    s2_n_r   <= s2_n_nxt;
    s2_max_r <= s1_max_r;
  end

  // round half up: hue = (85n + d) / 2d, sat = (510d + max) / 2max
  always_ff @(posedge clk) begin
    s3_hnum_r <= NUM_W'(s2_n_r) * NUM_W'(rhsv_pkg::HUE_MUL) + NUM_W'(s2_d_r);
    s3_snum_r <= NUM_W'(s2_d_r) * NUM_W'(rhsv_pkg::SAT_MUL) + NUM_W'(s2_max_r);
    s3_hden_r <= (s2_d_r == '0) ? DEN_W'(1) : {s2_d_r, 1'b0};
    s3_sden_r <= (s2_max_r == '0) ? DEN_W'(1) : {s2_max_r, 1'b0};
    s3_max_r  <= s2_max_r;
  end

  rhsv_div u_hue_div (
    .clk  (clk),
    .num  (s3_hnum_r),
    .den  (s3_hden_r),
    .quot (out_hue)
  );

  rhsv_div u_sat_div (
    .clk  (clk),
    .num  (s3_snum_r),
    .den  (s3_sden_r),
    .quot (out_saturation)
  );

  always_ff @(posedge clk) begin
    br_r[0] <= s3_max_r;
    for (int i = 1; i < Q_W; i++) begin
      br_r[i] <= br_r[i-1];
    end
  end

  assign out_brightness = br_r[Q_W-1];

  a_out_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching input beat");

  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturation == '0 |-> out_hue == '0)
    else $error("zero saturation with nonzero hue");

  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brightness == '0 |-> out_saturation == '0)
    else $error("black pixel with nonzero saturation");

endmodule
